@@ rtl/gpscal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpscal_pkg;

    // field widths
    localparam int WEEK_W  = 13;
    localparam int SEC_W   = 20;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SECM_W  = 6;

    // internal value widths
    localparam int DIW_W   = 4;   // day in week, up to 12 for any input
    localparam int DAYS_W  = 16;  // days since 1 jan 1980
    localparam int YRS_W   = 8;   // years since 1980
    localparam int REMD_W  = 17;  // seconds within the day
    localparam int REMH_W  = 12;  // seconds within the hour
    localparam int DOY_W   = 9;   // day of year, 1..366

    typedef logic [DOY_W-1:0] doy_t;
    typedef logic [YRS_W-1:0] years_t;

    // calendar constants
    localparam logic [SEC_W-1:0]  DAY_SECONDS      = 20'd86400;
    localparam logic [REMD_W-1:0] HOUR_SECONDS     = 17'd3600;
    localparam logic [REMH_W-1:0] MINUTE_SECONDS   = 12'd60;
    localparam logic [DAYS_W-1:0] WEEK_DAYS        = 16'd7;
    localparam logic [DAYS_W-1:0] YEAR_DAYS        = 16'd365;
    localparam logic [DAYS_W-1:0] EPOCH_DAY_OFFSET = 16'd5;
    localparam logic [YEAR_W-1:0] BASE_YEAR        = 12'd1980;
    localparam logic [YEAR_W-1:0] MAX_YEAR         = 12'd2099;
    localparam logic [WEEK_W-1:0] MAX_WEEK         = 13'd6262;
    localparam logic [SEC_W-1:0]  MAX_SECOND       = 20'd604799;

    // reciprocal multipliers, exact over the full input range
    // (sec >> 7) / 675 == sec / 86400
    localparam logic [12:0] DIW_RECIP   = 13'd6214;   // shift 22
    // (rem >> 4) / 225 == rem / 3600
    localparam logic [12:0] HOUR_RECIP  = 13'd4661;   // shift 20
    // (rem >> 2) / 15 == rem / 60 for rem below 3600
    localparam logic [10:0] MIN_RECIP   = 11'd1093;   // shift 14
    // days / 365 for days below 2^16
    localparam logic [15:0] YEAR_RECIP  = 16'd45965;  // shift 24

    // cumulative month start, index 0..12
    function automatic doy_t month_start(input logic leap, input logic [3:0] idx);
        doy_t v;
        v = '0;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = leap ? 9'd60  : 9'd59;
            4'd3:    v = leap ? 9'd91  : 9'd90;
            4'd4:    v = leap ? 9'd121 : 9'd120;
            4'd5:    v = leap ? 9'd152 : 9'd151;
            4'd6:    v = leap ? 9'd182 : 9'd181;
            4'd7:    v = leap ? 9'd213 : 9'd212;
            4'd8:    v = leap ? 9'd244 : 9'd243;
            4'd9:    v = leap ? 9'd274 : 9'd273;
            4'd10:   v = leap ? 9'd305 : 9'd304;
            4'd11:   v = leap ? 9'd335 : 9'd334;
            4'd12:   v = leap ? 9'd366 : 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gps_week_second_to_calendar_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// gps week and second of week to calendar date and time of day
//
// input channel: a word (week_number, seconds_of_week) is taken at a rising
// edge where start is high and busy is low; busy is held low, so a new word
// may be issued in every cycle
// output channel: done is high for exactly one cycle with the result word
// (cal_year .. out_of_range) on the result ports; the receiver cannot stall
// and takes each word at the edge that ends its cycle
// pipeline: each word passes through six register stages of reciprocal
// multiplies and compares before its result is on the ports
// throughput: one word per cycle; busy never rises and every stage takes a
// new word in each cycle
// reset: asynchronous, clears the stage valid bits and done; words in flight
// are dropped, no results are produced for them
// out_of_range flags week past 6262, second past 604799 or year past 2099;
// the date and time fields are still computed from the inputs as given

module gps_week_second_to_calendar_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [gpscal_pkg::WEEK_W-1:0]     week_number,
    input  wire logic [gpscal_pkg::SEC_W-1:0]      seconds_of_week,
    output logic                                   done,
    output logic [gpscal_pkg::YEAR_W-1:0]          cal_year,
    output logic [gpscal_pkg::MONTH_W-1:0]         cal_month,
    output logic [gpscal_pkg::DAY_W-1:0]           day_of_month,
    output logic [gpscal_pkg::HOUR_W-1:0]          hour_of_day,
    output logic [gpscal_pkg::MIN_W-1:0]           minute_of_hour,
    output logic [gpscal_pkg::SECM_W-1:0]          second_of_minute,
    output logic                                   out_of_range
);

    // pipeline never stalls
    assign busy = 1'b0;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    assign done = done_reg;

    // stage 1: day in week by reciprocal, range flag on the raw inputs
    logic [gpscal_pkg::WEEK_W-1:0] week_s1_reg;
    logic [gpscal_pkg::SEC_W-1:0]  sec_s1_reg;
    logic [gpscal_pkg::DIW_W-1:0]  diw_s1_reg, diw_s1_next;
    logic                          flag_s1_reg, flag_s1_next;
    logic [25:0]                   diw_prod;

    always_comb
    begin
        diw_prod     = 26'(seconds_of_week[gpscal_pkg::SEC_W-1:7])
                       * 26'(gpscal_pkg::DIW_RECIP);
        diw_s1_next  = diw_prod[25:22];
        flag_s1_next = (week_number > gpscal_pkg::MAX_WEEK)
                       || (seconds_of_week > gpscal_pkg::MAX_SECOND);
    end

    always_ff @(posedge clk)
    begin
        week_s1_reg <= week_number;
        sec_s1_reg  <= seconds_of_week;
        diw_s1_reg  <= diw_s1_next;
        flag_s1_reg <= flag_s1_next;
    end

    // stage 2: seconds within the day, total days
    logic [gpscal_pkg::REMD_W-1:0] remd_s2_reg, remd_s2_next;
    logic [gpscal_pkg::DAYS_W-1:0] days_s2_reg, days_s2_next;
    logic                          flag_s2_reg;
    logic [gpscal_pkg::SEC_W-1:0]  day_secs;

    always_comb
    begin
        day_secs     = gpscal_pkg::SEC_W'(diw_s1_reg) * gpscal_pkg::DAY_SECONDS;
        remd_s2_next = gpscal_pkg::REMD_W'(sec_s1_reg - day_secs);
        days_s2_next = gpscal_pkg::DAYS_W'(week_s1_reg) * gpscal_pkg::WEEK_DAYS
                       + gpscal_pkg::DAYS_W'(diw_s1_reg) + gpscal_pkg::EPOCH_DAY_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        remd_s2_reg <= remd_s2_next;
        days_s2_reg <= days_s2_next;
        flag_s2_reg <= flag_s1_reg;
    end

    // stage 3: hour and whole years by reciprocal
    logic [gpscal_pkg::REMD_W-1:0] remd_s3_reg;
    logic [gpscal_pkg::DAYS_W-1:0] days_s3_reg;
    logic [gpscal_pkg::HOUR_W-1:0] hour_s3_reg, hour_s3_next;
    gpscal_pkg::years_t            yrs_s3_reg, yrs_s3_next;
    logic                          flag_s3_reg;
    logic [25:0]                   hour_prod;
    logic [31:0]                   yrs_prod;

    always_comb
    begin
        hour_prod    = 26'(remd_s2_reg[gpscal_pkg::REMD_W-1:4])
                       * 26'(gpscal_pkg::HOUR_RECIP);
        hour_s3_next = hour_prod[24:20];
        yrs_prod     = 32'(days_s2_reg) * 32'(gpscal_pkg::YEAR_RECIP);
        yrs_s3_next  = yrs_prod[31:24];
    end

    always_ff @(posedge clk)
    begin
        remd_s3_reg <= remd_s2_reg;
        days_s3_reg <= days_s2_reg;
        hour_s3_reg <= hour_s3_next;
        yrs_s3_reg  <= yrs_s3_next;
        flag_s3_reg <= flag_s2_reg;
    end

    // stage 4: seconds within the hour, day of year less passed leap days
    logic [gpscal_pkg::REMH_W-1:0] remh_s4_reg, remh_s4_next;
    logic [gpscal_pkg::HOUR_W-1:0] hour_s4_reg;
    gpscal_pkg::years_t            yrs_s4_reg;
    logic signed [9:0]             doy_s4_reg, doy_s4_next;
    logic                          flag_s4_reg;
    logic [gpscal_pkg::REMD_W-1:0] hour_secs;
    logic [gpscal_pkg::DAYS_W-1:0] yrs_days;
    logic [gpscal_pkg::DAYS_W-1:0] day_in_year;
    logic [8:0]                    yrs_plus3;
    logic [6:0]                    leap_days;

    always_comb
    begin
        hour_secs    = gpscal_pkg::REMD_W'(hour_s3_reg) * gpscal_pkg::HOUR_SECONDS;
        remh_s4_next = gpscal_pkg::REMH_W'(remd_s3_reg - hour_secs);
        yrs_days     = gpscal_pkg::DAYS_W'(yrs_s3_reg) * gpscal_pkg::YEAR_DAYS;
        day_in_year  = days_s3_reg - yrs_days;
        yrs_plus3    = 9'(yrs_s3_reg) + 9'd3;
        leap_days    = yrs_plus3[8:2];
        doy_s4_next  = $signed({1'b0, day_in_year[8:0]}) + 10'sd1
                       - $signed({3'b0, leap_days});
    end

    always_ff @(posedge clk)
    begin
        remh_s4_reg <= remh_s4_next;
        hour_s4_reg <= hour_s3_reg;
        yrs_s4_reg  <= yrs_s3_reg;
        doy_s4_reg  <= doy_s4_next;
        flag_s4_reg <= flag_s3_reg;
    end

    // stage 5: minute by reciprocal, roll back into the prior year
    logic [gpscal_pkg::REMH_W-1:0] remh_s5_reg;
    logic [gpscal_pkg::HOUR_W-1:0] hour_s5_reg;
    logic [gpscal_pkg::MIN_W-1:0]  min_s5_reg, min_s5_next;
    gpscal_pkg::years_t            yrs_s5_reg, yrs_s5_next;
    gpscal_pkg::doy_t              doy_s5_reg, doy_s5_next;
    logic                          leap_s5_reg, leap_s5_next;
    logic                          flag_s5_reg;
    logic [20:0]                   min_prod;
    logic signed [9:0]             doy_fix;

    always_comb
    begin
        min_prod    = 21'(remh_s4_reg[gpscal_pkg::REMH_W-1:2])
                      * 21'(gpscal_pkg::MIN_RECIP);
        min_s5_next = min_prod[19:14];
        yrs_s5_next = yrs_s4_reg;
        doy_fix     = doy_s4_reg;
        if (doy_s4_reg <= 10'sd0)
        begin
            yrs_s5_next = yrs_s4_reg - 8'd1;
            if (yrs_s5_next[1:0] != 2'd0)
                doy_fix = doy_s4_reg + 10'sd365;
            else
                doy_fix = doy_s4_reg + 10'sd366;
        end
        doy_s5_next  = doy_fix[8:0];
        leap_s5_next = (yrs_s5_next[1:0] == 2'd0);
    end

    always_ff @(posedge clk)
    begin
        remh_s5_reg <= remh_s4_reg;
        hour_s5_reg <= hour_s4_reg;
        min_s5_reg  <= min_s5_next;
        yrs_s5_reg  <= yrs_s5_next;
        doy_s5_reg  <= doy_s5_next;
        leap_s5_reg <= leap_s5_next;
        flag_s5_reg <= flag_s4_reg;
    end

    // stage 6: second, month search, day of month, year and range flag
    logic [gpscal_pkg::MONTH_W-1:0] month_next;
    logic [gpscal_pkg::REMH_W-1:0]  min_secs;
    logic [gpscal_pkg::REMH_W-1:0]  sec_rem;
    gpscal_pkg::doy_t               day_full;
    logic [gpscal_pkg::YEAR_W-1:0]  year_next;

    always_comb
    begin
        month_next = 4'd1;
        for (int m = 1; m < 12; m++)
        begin
            if (doy_s5_reg > gpscal_pkg::month_start(leap_s5_reg, 4'(m)))
                month_next = month_next + 4'd1;
        end
        day_full  = doy_s5_reg - gpscal_pkg::month_start(leap_s5_reg, month_next - 4'd1);
        min_secs  = gpscal_pkg::REMH_W'(min_s5_reg) * gpscal_pkg::MINUTE_SECONDS;
        sec_rem   = remh_s5_reg - min_secs;
        year_next = gpscal_pkg::YEAR_W'(yrs_s5_reg) + gpscal_pkg::BASE_YEAR;
    end

    always_ff @(posedge clk)
    begin
        cal_year         <= year_next;
        cal_month        <= month_next;
        day_of_month     <= day_full[gpscal_pkg::DAY_W-1:0];
        hour_of_day      <= hour_s5_reg;
        minute_of_hour   <= min_s5_reg;
        second_of_minute <= sec_rem[gpscal_pkg::SECM_W-1:0];
        out_of_range     <= flag_s5_reg || (year_next > gpscal_pkg::MAX_YEAR);
    end

    // checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ##5 done)
        else $error("accepted word did not produce a result");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cal_month >= 4'd1) && (cal_month <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (day_of_month >= 5'd1) && (day_of_month <= 5'd31))
        else $error("day of month out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
                 && (second_of_minute <= 6'd59))
        else $error("time of day out of range");

    a_year_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |-> (cal_year <= gpscal_pkg::MAX_YEAR))
        else $error("year past limit without range flag");

endmodule

`default_nettype wire
